// ===== hw/rtl/vpl_pkg.sv =====
// ----------------------------------------------------------------------------
// vpl_pkg: shared constants for the velocity PI controller
// Fixed-point formats, register indexes and derived datapath widths.
// ----------------------------------------------------------------------------
package vpl_pkg;

    // encoder count width, taken from the low bits of each count field
    localparam int CountBits  = 16;
    localparam int FracBits   = 16;    // state and gain fraction bits
    localparam int StateW     = 40;
    localparam int GainW      = 32;
    localparam int TargetW    = 25;
    localparam int TargetFrac = 8;
    localparam int DriveW     = 32;

    localparam longint IntegLimit  = 100000;
    localparam longint IntegLimitQ = IntegLimit * (longint'(1) <<< FracBits);

    // configuration port
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] RegPropGain   = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegIntegGain  = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] RegTargetSpeed = CfgIdxW'(2);

    localparam logic signed [GainW-1:0]   PropGainRst   = GainW'(13107200);
    localparam logic signed [GainW-1:0]   IntegGainRst  = GainW'(6554);
    localparam logic signed [TargetW-1:0] TargetRst     = TargetW'(0);

    // error = (left + right) * 2^16 - target * 2^8
    localparam int ErrW = (((CountBits + 1 + FracBits) > (TargetW + FracBits - TargetFrac))
                          ? (CountBits + 1 + FracBits)
                          : (TargetW + FracBits - TargetFrac)) + 1;

    // numerator 4*filtered + error
    localparam int NumW = (((StateW + 2) > ErrW) ? (StateW + 2) : ErrW) + 1;

    // divide by five, four quotient bits per cycle
    localparam int DivDigitW = 4;
    localparam int DivSteps  = (NumW + DivDigitW - 1) / DivDigitW;
    localparam int QuoW      = DivSteps * DivDigitW;
    localparam int DivCntW   = $clog2(DivSteps + 1);

    // shared multiplier: gain times one slice of a state word
    localparam int LowW  = 24;
    localparam int MulBW = LowW + 1;
    localparam int MulW  = GainW + MulBW;
    localparam int AccW  = GainW + StateW + 1;

endpackage

// ===== hw/rtl/velocity_pi_with_lowpass.sv =====
// ----------------------------------------------------------------------------
// velocity_pi_with_lowpass: velocity PI controller with low-pass and clamp
// Filters the wheel speed error, integrates it with a clamp and drives a
// PI output, all in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall with the left and right encoder
//   counts. One word is taken when the block is idle; o_in_stall stays high
//   while a sample is being worked on.
//   Output channel: o_out_valid / i_out_stall with the drive value and the
//   integral clamp flag. The result sits in an output register, so the next
//   sample is taken while a result still waits; a stalled result holds.
//   Configuration: i_cfg_valid / o_cfg_ready with index and data; ready is
//   always high. Write only while no sample is in flight.
//   Sequence: from the accepted input word the block forms the numerator,
//   starts the divider and waits for the divide by five (radix-16 digits
//   plus done), then filters, updates the integral, makes four passes
//   through the shared 32x25 multiplier, rounds, saturates and loads the
//   output register. A new input word is taken only once the last sample
//   has gone to the output register.
//   A finished sample waits for the output register to drain if the
//   receiver stalls.
//   Reset: gains and target return to their defaults, the filter and the
//   integral return to zero, no result is pending.
module velocity_pi_with_lowpass (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [vpl_pkg::CountBits-1:0] i_left_count,
    input  logic signed [vpl_pkg::CountBits-1:0] i_right_count,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [vpl_pkg::DriveW-1:0]    o_drive_value,
    output logic                                 o_integral_clamped,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vpl_pkg::CfgIdxW-1:0]          i_cfg_index,
    input  logic [vpl_pkg::CfgDataW-1:0]         i_cfg_data
);
    import vpl_pkg::*;

    localparam int SumW = StateW + 1;
    localparam logic signed [SumW-1:0] LimPos = SumW'(IntegLimitQ);
    localparam logic signed [SumW-1:0] LimNeg = SumW'(-IntegLimitQ);
    localparam logic [QuoW-1:0] QPosMax = QuoW'((longint'(1) <<< (StateW - 1)) - 1);
    localparam logic [QuoW-1:0] QNegMax = QuoW'(longint'(1) <<< (StateW - 1));
    localparam logic signed [StateW-1:0] StateMax = {1'b0, {(StateW-1){1'b1}}};
    localparam logic signed [StateW-1:0] StateMin = {1'b1, {(StateW-1){1'b0}}};
    localparam logic [AccW-1:0] RndBias = {{(AccW-32){1'b0}}, {32{1'b1}}};
    localparam int YW = AccW - 32;

    typedef enum logic [3:0] {
        S_IDLE, S_NUM, S_DIV_GO, S_DIV_WAIT, S_FILT,
        S_INTEG, S_MUL, S_RND, S_SAT, S_DONE
    } t_state;

    t_state                     r_state;
    logic signed [GainW-1:0]    r_prop_gain;
    logic signed [GainW-1:0]    r_integ_gain;
    logic signed [TargetW-1:0]  r_target;
    logic signed [StateW-1:0]   r_filt;
    logic signed [StateW-1:0]   r_integ;
    logic signed [ErrW-1:0]     r_err;
    logic signed [NumW-1:0]     r_num;
    logic                       r_num_neg;
    logic                       r_clamped;
    logic [2:0]                 r_step;
    logic signed [MulW-1:0]     r_prod;
    logic                       r_prod_hi;
    logic signed [AccW-1:0]     r_acc;
    logic signed [DriveW-1:0]   r_drive;
    logic                       r_out_valid;
    logic signed [DriveW-1:0]   r_out_drive;
    logic                       r_out_clamped;

    logic                       in_accept;
    logic                       out_free;
    logic signed [ErrW-1:0]     w_sum;
    logic signed [ErrW-1:0]     w_err;
    logic [NumW-1:0]            w_mag;
    logic                       div_start;
    logic                       div_done;
    logic [QuoW-1:0]            div_quo;
    logic signed [StateW-1:0]   w_filt;
    logic signed [SumW-1:0]     w_isum;
    logic signed [GainW-1:0]    mul_a;
    logic signed [StateW-1:0]   mul_st;
    logic signed [MulBW-1:0]    mul_b;
    logic signed [AccW-1:0]     w_addend;
    logic signed [YW-1:0]       w_y;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // speed error in Q16
    assign w_sum = ErrW'(i_left_count) + ErrW'(i_right_count);
    assign w_err = (w_sum <<< FracBits) - (ErrW'(r_target) <<< (FracBits - TargetFrac));

    assign w_mag     = r_num[NumW-1] ? NumW'(-r_num) : NumW'(r_num);
    assign div_start = (r_state == S_DIV_GO);

    vpl_div5 u_div5 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (w_mag),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // restore sign of the truncated quotient and saturate to the state range
    always_comb begin
        if (!r_num_neg) begin
            w_filt = (div_quo > QPosMax) ? StateMax : StateW'(div_quo);
        end else begin
            w_filt = (div_quo > QNegMax) ? StateMin : -StateW'(div_quo);
        end
    end

    assign w_isum = SumW'(r_integ) + SumW'(r_filt);

    // multiplier operands: step bit 1 picks the term, bit 0 the state slice
    assign mul_a  = r_step[1] ? r_integ_gain : r_prop_gain;
    assign mul_st = r_step[1] ? r_integ : r_filt;
    assign mul_b  = r_step[0]
                  ? MulBW'($signed(mul_st[StateW-1:LowW]))
                  : $signed({1'b0, mul_st[LowW-1:0]});

    assign w_addend = r_prod_hi ? (AccW'(r_prod) <<< LowW) : AccW'(r_prod);
    assign w_y      = r_acc[AccW-1:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prop_gain   <= PropGainRst;
            r_integ_gain  <= IntegGainRst;
            r_target      <= TargetRst;
            r_filt        <= '0;
            r_integ       <= '0;
            r_step        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    RegPropGain:    r_prop_gain  <= GainW'(i_cfg_data);
                    RegIntegGain:   r_integ_gain <= GainW'(i_cfg_data);
                    RegTargetSpeed: r_target     <= i_cfg_data[TargetW-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_err   <= w_err;
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_num   <= (NumW'(r_filt) <<< 2) + NumW'(r_err);
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_num_neg <= r_num[NumW-1];
                    r_state   <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= S_FILT;
                    end
                end
                S_FILT: begin
                    r_filt  <= w_filt;
                    r_state <= S_INTEG;
                end
                S_INTEG: begin
                    if (w_isum > LimPos) begin
                        r_integ   <= StateW'(LimPos);
                        r_clamped <= 1'b1;
                    end else if (w_isum < LimNeg) begin
                        r_integ   <= StateW'(LimNeg);
                        r_clamped <= 1'b1;
                    end else begin
                        r_integ   <= w_isum[StateW-1:0];
                        r_clamped <= 1'b0;
                    end
                    r_acc   <= '0;
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // multiply for step n while the product of step n-1 accumulates
                    if (r_step != 3'd4) begin
                        r_prod    <= mul_a * mul_b;
                        r_prod_hi <= r_step[0];
                    end
                    if (r_step != 3'd0) begin
                        r_acc <= r_acc + w_addend;
                    end
                    if (r_step == 3'd4) begin
                        r_state <= S_RND;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_RND: begin
                    // bias negative sums so the shift truncates toward zero
                    r_acc   <= r_acc + (r_acc[AccW-1] ? $signed(RndBias) : '0);
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (w_y[YW-1:DriveW-1] == '0 || w_y[YW-1:DriveW-1] == '1) begin
                        r_drive <= w_y[DriveW-1:0];
                    end else if (w_y[YW-1]) begin
                        r_drive <= {1'b1, {(DriveW-1){1'b0}}};
                    end else begin
                        r_drive <= {1'b0, {(DriveW-1){1'b1}}};
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_drive   <= r_drive;
                        r_out_clamped <= r_clamped;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_drive_value      = r_out_drive;
    assign o_integral_clamped = r_out_clamped;

endmodule

// ===== hw/rtl/vpl_div5.sv =====
// ----------------------------------------------------------------------------
// vpl_div5: iterative unsigned divide by five
// Long division, four dividend bits per cycle, quotient valid on o_done.
// ----------------------------------------------------------------------------
module vpl_div5 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vpl_pkg::NumW-1:0]   i_dividend,
    output logic                       o_done,
    output logic [vpl_pkg::QuoW-1:0]   o_quotient
);
    import vpl_pkg::*;

    localparam logic [3:0] Five = 4'd5;

    logic                 r_busy;
    logic                 r_done;
    logic [DivCntW-1:0]   r_cnt;
    logic [QuoW-1:0]      r_shift;
    logic [QuoW-1:0]      r_quo;
    logic [2:0]           r_rem;

    logic [2:0]           n_rem;
    logic [DivDigitW-1:0] n_qdig;

    // one radix-16 digit: four restoring steps on a 3-bit remainder
    always_comb begin
        logic [3:0] t;
        n_rem = r_rem;
        n_qdig = '0;
        for (int k = 0; k < DivDigitW; k++) begin
            t = {n_rem, r_shift[QuoW-1-k]};
            if (t >= Five) begin
                n_rem = 3'(t - Five);
                n_qdig[DivDigitW-1-k] = 1'b1;
            end else begin
                n_rem = t[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= DivCntW'(DivSteps);
                r_shift <= QuoW'(i_dividend);
                r_rem   <= '0;
                r_quo   <= '0;
            end else if (r_busy) begin
                r_shift <= r_shift << DivDigitW;
                r_rem   <= n_rem;
                r_quo   <= {r_quo[QuoW-DivDigitW-1:0], n_qdig};
                r_cnt   <= r_cnt - DivCntW'(1);
                if (r_cnt == DivCntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/vpl_checker.sv =====
// ----------------------------------------------------------------------------
// vpl_checker: port-level checks for the velocity PI controller
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module vpl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [vpl_pkg::DriveW-1:0]        o_drive_value,
    input logic                              o_integral_clamped
);
    import vpl_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_drive_value) && $stable(o_integral_clamped))
        else $error("result word changed while stalled");

    // one sample at a time: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a sample is in flight");

    // a new result only comes out of a busy sequencer
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a sample in flight");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind velocity_pi_with_lowpass vpl_checker u_vpl_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_drive_value      (o_drive_value),
    .o_integral_clamped (o_integral_clamped)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: checks velocity_pi_with_lowpass against a cycle-free predictor
// Sends encoder count pairs with random gaps while the receiver stalls at
// random. Each sample runs through a local model of the filter, integral
// clamp and PI sum; every result word is compared with the oldest
// prediction. Gains and target change between phases while the block idles.
// ----------------------------------------------------------------------------
module testbench;
    import vpl_pkg::*;

    localparam logic [CfgIdxW-1:0] RegSpare = CfgIdxW'(3);
    localparam int     QuietCycles = 32;
    localparam longint StateMax    = (longint'(1) <<< 39) - 1;
    localparam longint StateMin    = -StateMax - 1;
    localparam longint ClampQ      = longint'(100000) * 65536;
    localparam logic signed [79:0] DriveMax = 80'sd2147483647;
    localparam logic signed [79:0] DriveMin = -80'sd2147483648;

    typedef struct packed {
        logic signed [DriveW-1:0] drive;
        logic                     clamped;
    } t_drive_word;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [CountBits-1:0] i_left_count;
    logic signed [CountBits-1:0] i_right_count;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [DriveW-1:0]    o_drive_value;
    logic                        o_integral_clamped;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CfgIdxW-1:0]          i_cfg_index;
    logic [CfgDataW-1:0]         i_cfg_data;

    // controller model: configuration and state
    logic signed [GainW-1:0]   prop_q;
    logic signed [GainW-1:0]   integ_gain_q;
    logic signed [TargetW-1:0] target_q;
    longint                    filt_q;
    longint                    integ_q;

    t_drive_word pending_drive[$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          tx_gap_max   = 16;
    int          rx_wait_max  = 16;
    int          long_hold    = 0;

    velocity_pi_with_lowpass u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_left_count       (i_left_count),
        .i_right_count      (i_right_count),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_drive_value      (o_drive_value),
        .o_integral_clamped (o_integral_clamped),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_drive_word advance_controller(logic signed [CountBits-1:0] left,
                                                       logic signed [CountBits-1:0] right);
        longint              err;
        longint              f;
        logic signed [79:0]  acc;
        logic signed [79:0]  whole;
        t_drive_word         w;
        err = (longint'(left) + longint'(right)) * 65536 - longint'(target_q) * 256;
        f = (4 * filt_q + err) / 5;
        if (f > StateMax) begin
            f = StateMax;
        end else if (f < StateMin) begin
            f = StateMin;
        end
        filt_q = f;
        integ_q = integ_q + f;
        w.clamped = 1'b0;
        if (integ_q > ClampQ) begin
            integ_q = ClampQ;
            w.clamped = 1'b1;
        end else if (integ_q < -ClampQ) begin
            integ_q = -ClampQ;
            w.clamped = 1'b1;
        end
        acc = prop_q * filt_q + integ_gain_q * integ_q;
        // drop 32 fraction bits toward zero
        if (acc < 0) begin
            whole = -((-acc) >>> 32);
        end else begin
            whole = acc >>> 32;
        end
        if (whole > DriveMax) begin
            w.drive = DriveMax[DriveW-1:0];
        end else if (whole < DriveMin) begin
            w.drive = DriveMin[DriveW-1:0];
        end else begin
            w.drive = whole[DriveW-1:0];
        end
        return w;
    endfunction

    function automatic logic signed [CountBits-1:0] pick_count(int mode);
        int c;
        if (mode < 4) begin
            return CountBits'($urandom);
        end else if (mode < 8) begin
            // stay near the target so the error is small
            c = int'(target_q) / 512 + int'($urandom_range(0, 128)) - 64;
            if (c > 32767) c = 32767;
            if (c < -32768) c = -32768;
            return CountBits'(c);
        end
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    task automatic send_sample(input logic signed [CountBits-1:0] left,
                               input logic signed [CountBits-1:0] right);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_left_count  <= left;
        i_right_count <= right;
        do @(posedge i_clk); while (o_in_stall);
        pending_drive.push_back(advance_controller(left, right));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (QuietCycles) @(posedge i_clk);
    endtask

    task automatic write_word(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            RegPropGain:    prop_q       = data[GainW-1:0];
            RegIntegGain:   integ_gain_q = data[GainW-1:0];
            RegTargetSpeed: target_q     = data[TargetW-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CfgDataW-1:0] prop, input logic [CfgDataW-1:0] integ,
                             input logic [CfgDataW-1:0] tgt, input bit poke_spare);
        drain_results();
        write_word(RegPropGain, prop);
        write_word(RegIntegGain, integ);
        write_word(RegTargetSpeed, tgt);
        if (poke_spare) begin
            write_word(RegSpare, $urandom);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // From reset: jump the filter to 10000 counts, hold it, land on the
    // integral limit exactly on the tenth sample, then cross it.
    task automatic test_integral_limit();
        send_sample(16'sd25000, 16'sd25000);
        repeat (10) send_sample(16'sd5000, 16'sd5000);
    endtask

    task automatic test_field_extremes();
        configure(32'h7fffffff, 32'h7fffffff, 32'h0, 1'b0);
        repeat (3) send_sample(16'sh7fff, 16'sh7fff);
        repeat (4) send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'shffff, 16'shffff);
        configure(32'h80000000, 32'h80000000, 32'h00ffffff, 1'b0);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        // upper data bits fall outside the target field
        configure(32'h80000000, 32'h80000000, 32'hff000000, 1'b0);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
    endtask

    task automatic test_spare_index();
        configure(32'd13107200, 32'd6554, 32'd25600, 1'b1);
        send_sample(16'sd40, 16'sd70);
        send_sample(16'sd120, -16'sd3);
    endtask

    task automatic test_backpressure();
        tx_gap_max  = 0;
        rx_wait_max = 16;
        long_hold   = 300;
        repeat (40) send_sample(CountBits'($urandom), CountBits'($urandom));
    endtask

    task automatic test_random_phases();
        int tx_pick[8] = '{16, 0, 16, 4, 0, 16, 8, 16};
        int rx_pick[8] = '{16, 0, 0, 16, 16, 4, 16, 16};
        logic [CfgDataW-1:0] p, g, t;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0, 7: begin
                    p = 32'd13107200;
                    g = 32'd6554;
                    t = $urandom_range(0, 4095) * 256 - 524288;
                end
                1: begin
                    p = 32'h7fffffff;
                    g = 32'h80000000;
                    t = 32'h00ffffff;
                end
                2: begin
                    p = 32'h80000000;
                    g = 32'h7fffffff;
                    t = 32'h01000000;
                end
                3, 6: begin
                    p = $urandom_range(0, 1 << 21) - (1 << 20);
                    g = $urandom_range(0, 1 << 21) - (1 << 20);
                    t = (ph == 3) ? $urandom : $urandom_range(0, 4095) * 256 - 524288;
                end
                5: begin
                    p = 32'h0;
                    g = 32'h0;
                    t = $urandom;
                end
                default: begin
                    p = $urandom;
                    g = $urandom;
                    t = $urandom;
                end
            endcase
            configure(p, g, t, ph == 2 || ph == 5);
            tx_gap_max  = tx_pick[ph];
            rx_wait_max = rx_pick[ph];
            repeat (190) begin
                int mode;
                mode = $urandom_range(0, 9);
                send_sample(pick_count(mode), pick_count(mode));
            end
        end
    endtask

    // receiver: per word draw a stall length, or take a long hold on request
    initial begin : result_drain
        int n;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (long_hold) @(posedge i_clk);
                long_hold = 0;
            end
            n = (rx_wait_max == 0) ? 0 : $urandom_range(0, rx_wait_max);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (n - 1) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_drive_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: no prediction waiting, got drive %0d clamp %0b",
                             results_seen, o_drive_value, o_integral_clamped);
                end
            end else begin
                want = pending_drive.pop_front();
                if (o_drive_value !== want.drive || o_integral_clamped !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: drive exp %0d got %0d, clamp exp %0b got %0b",
                                 results_seen, want.drive, o_drive_value,
                                 want.clamped, o_integral_clamped);
                    end
                end
            end
        end
    end

    initial begin
        prop_q       = 32'sd13107200;
        integ_gain_q = 32'sd6554;
        target_q     = '0;
        filt_q       = 0;
        integ_q      = 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_left_count  <= '0;
        i_right_count <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_integral_limit();
        test_field_extremes();
        test_spare_index();
        test_backpressure();
        test_random_phases();
        drain_results();

        if (mismatches == 0 && pending_drive.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
